>>> design/predator_prey_grid_automaton_top_assert.svh
// assertion macros shared by the grid automaton rtl
// expects clk and rst_n in the scope of use
`ifndef PREDATOR_PREY_GRID_AUTOMATON_TOP_ASSERT_SVH
`define PREDATOR_PREY_GRID_AUTOMATON_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PPGA_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define PPGA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define PPGA_ASSERT(lbl, expr)
`define PPGA_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> design/ppga_pkg.sv
// types, codes and helpers for the predator-prey grid automaton
// no dependencies
`default_nettype none
package ppga_pkg;
  typedef logic signed [5:0] cell_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_st_t;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  localparam logic [2:0] CFG_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_FMAX    = 3'd2;
  localparam logic [2:0] CFG_SMAX    = 3'd3;
  localparam logic [2:0] CFG_FBREED  = 3'd4;
  localparam logic [2:0] CFG_SBREED  = 3'd5;
  localparam logic [2:0] CFG_MODULUS = 3'd6;
  localparam logic [2:0] CFG_SEED    = 3'd7;

  localparam logic [15:0] LFSR_MASK = 16'hB400;

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] t;
    t = s >> 1;
    if (s[0]) t = t ^ LFSR_MASK;
    return t;
  endfunction
endpackage
`default_nettype wire

>>> design/predator_prey_grid_automaton_top.sv
// predator-prey grid automaton: two grid banks, window sequencer, remainder unit
// depends on ppga_pkg, ppga_ram, ppga_mod and the assertion header
//
// channel   direction  words
// in_       slave      one request: write cell, read cell or step
// out_      master     one reply per request
// cfg_      write      register index and data, no handshake
//
// after reset the current bank is cleared, in_tready low meanwhile
// a step sweeps all MAX_COLS*MAX_ROWS cells:
// a used cell in row 0 reads nine window cells, other used cells three, unused ones one,
// plus a remainder pass for each shark while the modulus is nonzero (serial remainder unit)
// one memory read port per bank sets the pace; a stalled reply holds the block
`include "predator_prey_grid_automaton_top_assert.svh"
`default_nettype none
module predator_prey_grid_automaton_top #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // req_type, cell_col, cell_row, cell_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // read_value, request_done
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import ppga_pkg::*;

  localparam int WW    = $clog2(MAX_COLS + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_GRD  = 3'd4;
  localparam logic [2:0] S_GEV  = 3'd5;
  localparam logic [2:0] S_GMOD = 3'd6;

  logic [2:0]  state_r;
  logic [AW-1:0] clr_r;
  logic        bank_r;
  logic [6:0]  gw_r, gh_r;
  logic [4:0]  fmax_r, smax_r, fbr_r, sbr_r;
  logic [7:0]  dm_r;
  logic [15:0] lfsr_r;
  logic [CW-1:0] c_r;
  logic [RW-1:0] r_r;
  logic [3:0]  k_r;
  cell_t       win_r [3][3];
  cell_t       ctr_r, res_r;
  logic        rd_ok_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
                                            input logic [CW-1:0] col);
    return AW'(AW'(row) * AW'(MAX_COLS) + AW'(col));
  endfunction

  function automatic logic [3:0] slot_of(input logic [3:0] idx, input logic full);
    logic [3:0] s;
    s = 4'b0000;
    if (!full) s = {idx[1:0], 2'd2};
    else begin
      case (idx)
        4'd0: s = {2'd0, 2'd0};
        4'd1: s = {2'd0, 2'd1};
        4'd2: s = {2'd0, 2'd2};
        4'd3: s = {2'd1, 2'd0};
        4'd4: s = {2'd1, 2'd1};
        4'd5: s = {2'd1, 2'd2};
        4'd6: s = {2'd2, 2'd0};
        4'd7: s = {2'd2, 2'd1};
        default: s = {2'd2, 2'd2};
      endcase
    end
    return s;
  endfunction

  // request fields
  logic [1:0]  rq_type;
  logic [5:0]  rq_col, rq_row;
  cell_t       rq_val;
  logic        rq_ok, accept;
  logic [AW-1:0] rq_addr;

  assign rq_type = in_tdata[1:0];
  assign rq_col  = in_tdata[7:2];
  assign rq_row  = in_tdata[13:8];
  assign rq_val  = (in_tdata[19:14] == 6'b100000) ? -6'sd31 : cell_t'(in_tdata[19:14]);
  assign rq_ok   = (11'(rq_col) < 11'(MAX_COLS)) && (11'(rq_row) < 11'(MAX_ROWS));
  assign rq_addr = addr_of(RW'(rq_row), CW'(rq_col));
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // used area
  logic [WW-1:0] w_use;
  logic [HW-1:0] h_use;
  always_comb begin
    if (gw_r < 7'd3) w_use = WW'(3);
    else if (16'(gw_r) > 16'(MAX_COLS)) w_use = WW'(MAX_COLS);
    else w_use = WW'(gw_r);
    if (gh_r < 7'd3) h_use = HW'(3);
    else if (16'(gh_r) > 16'(MAX_ROWS)) h_use = HW'(MAX_ROWS);
    else h_use = HW'(gh_r);
  end

  logic          used_cell, full, last_row, last_col;
  logic [WW-1:0] c_plus;
  logic [HW-1:0] r_plus;
  logic [CW-1:0] cm, cp;
  logic [RW-1:0] rm, rp;
  logic [3:0]    nreads, sl, ps;
  logic [CW-1:0] sel_c;
  logic [RW-1:0] sel_r;

  assign used_cell = (WW'(c_r) < w_use) && (HW'(r_r) < h_use);
  assign full     = (r_r == '0);
  assign last_row = (r_r == RW'(MAX_ROWS - 1));
  assign last_col = (c_r == CW'(MAX_COLS - 1));
  assign c_plus   = WW'(c_r) + WW'(1);
  assign r_plus   = HW'(r_r) + HW'(1);
  assign cm       = (c_r == '0) ? CW'(w_use - WW'(1)) : c_r - CW'(1);
  assign cp       = (c_plus == w_use) ? '0 : CW'(c_plus);
  assign rm       = (r_r == '0) ? RW'(h_use - HW'(1)) : r_r - RW'(1);
  assign rp       = (r_plus == h_use) ? '0 : RW'(r_plus);
  assign nreads   = !used_cell ? 4'd1 : (full ? 4'd9 : 4'd3);
  assign sl       = slot_of(k_r, full);
  assign ps       = slot_of(k_r - 4'd1, full);

  always_comb begin
    sel_c = c_r;
    sel_r = r_r;
    if (used_cell) begin
      case (sl[3:2])
        2'd0:    sel_c = cm;
        2'd2:    sel_c = cp;
        default: sel_c = c_r;
      endcase
      case (sl[1:0])
        2'd0:    sel_r = rm;
        2'd2:    sel_r = rp;
        default: sel_r = r_r;
      endcase
    end
  end

  // neighbour counts and next value
  cell_t      v, nv;
  logic [3:0] fish_c, shark_c, fb_c, sb_c;
  logic       rnd, shark_here, use_mod;
  mod_st_t    mod_st;
  logic [15:0] lfsr_nx;

  assign v          = win_r[1][1];
  assign shark_here = used_cell && (v < 0);
  assign use_mod    = shark_here && (dm_r != 8'd0);
  assign rnd        = (state_r == S_GMOD) && mod_st.zero;
  assign lfsr_nx    = lfsr_step(lfsr_r);

  always_comb begin
    cell_t n;
    logic [4:0] mag;
    fish_c  = '0;
    shark_c = '0;
    fb_c    = '0;
    sb_c    = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        n   = win_r[i][j];
        mag = 5'(-n);
        if (!(i == 1 && j == 1)) begin
          if (n > 0) begin
            fish_c = fish_c + 4'd1;
            if (n[4:0] >= fbr_r) fb_c = fb_c + 4'd1;
          end else if (n < 0) begin
            shark_c = shark_c + 4'd1;
            if (mag >= sbr_r) sb_c = sb_c + 4'd1;
          end
        end
      end
    end
  end

  always_comb begin
    logic [4:0] vm;
    vm = 5'(-v);
    if (v == 0) begin
      if (fish_c >= 4'd3 && fb_c >= 4'd3 && shark_c < 4'd4) nv = 6'sd1;
      else if (shark_c >= 4'd3 && sb_c >= 4'd3 && fish_c < 4'd4) nv = -6'sd1;
      else nv = 6'sd0;
    end else if (v > 0) begin
      if (v[4:0] > fmax_r || shark_c >= 4'd5 || fish_c == 4'd8) nv = 6'sd0;
      else nv = (v < 6'sd31) ? v + 6'sd1 : 6'sd31;
    end else begin
      if (vm > smax_r || (shark_c >= 4'd6 && fish_c == 4'd0) || rnd) nv = 6'sd0;
      else nv = (v > -6'sd31) ? v - 6'sd1 : -6'sd31;
    end
  end

  logic gen_we, mod_start;
  assign gen_we    = ((state_r == S_GEV) && !use_mod) || ((state_r == S_GMOD) && mod_st.done);
  assign mod_start = (state_r == S_GEV) && use_mod;

  ppga_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (lfsr_nx),
    .divisor  (dm_r),
    .st       (mod_st)
  );

  // memory ports
  logic          we0, we1, rq_we;
  logic [AW-1:0] waddr, raddr, gaddr;
  cell_t         wdata, rd0, rd1, rd;

  assign rq_we = accept && (rq_type == REQ_WRITE) && rq_ok;
  assign gaddr = addr_of(r_r, c_r);
  assign raddr = (state_r == S_IDLE) ? rq_addr : addr_of(sel_r, sel_c);
  always_comb begin
    if (state_r == S_CLR) begin
      waddr = clr_r;
      wdata = 6'sd0;
    end else if (gen_we) begin
      waddr = gaddr;
      wdata = used_cell ? nv : ctr_r;
    end else begin
      waddr = rq_addr;
      wdata = rq_val;
    end
  end
  assign we0 = (state_r == S_CLR) || (rq_we && !bank_r) || (gen_we && bank_r);
  assign we1 = (rq_we && bank_r) || (gen_we && !bank_r);
  assign rd  = bank_r ? rd1 : rd0;

  ppga_ram #(.WIDTH(6), .DEPTH(DEPTH)) u_bank0 (
    .clk (clk), .we (we0), .waddr (waddr), .wdata (wdata), .raddr (raddr), .rdata (rd0)
  );
  ppga_ram #(.WIDTH(6), .DEPTH(DEPTH)) u_bank1 (
    .clk (clk), .we (we1), .waddr (waddr), .wdata (wdata), .raddr (raddr), .rdata (rd1)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r   <= 7'd64;
      gh_r   <= 7'd64;
      fmax_r <= 5'd10;
      smax_r <= 5'd20;
      fbr_r  <= 5'd2;
      sbr_r  <= 5'd3;
      dm_r   <= 8'd48;
      lfsr_r <= 16'd1;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_WIDTH:   gw_r   <= cfg_wdata[6:0];
          CFG_HEIGHT:  gh_r   <= cfg_wdata[6:0];
          CFG_FMAX:    fmax_r <= cfg_wdata[4:0];
          CFG_SMAX:    smax_r <= cfg_wdata[4:0];
          CFG_FBREED:  fbr_r  <= cfg_wdata[4:0];
          CFG_SBREED:  sbr_r  <= cfg_wdata[4:0];
          CFG_MODULUS: dm_r   <= cfg_wdata[7:0];
          CFG_SEED:    lfsr_r <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
          default:     ;
        endcase
      end else if (state_r == S_GEV && shark_here) begin
        lfsr_r <= lfsr_nx;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            res_r   <= 6'sd0;
            rd_ok_r <= rq_ok;
            c_r     <= '0;
            r_r     <= '0;
            k_r     <= '0;
            case (rq_type)
              REQ_READ: state_r <= S_RD;
              REQ_STEP: state_r <= S_GRD;
              default:  state_r <= S_OUT;
            endcase
          end
        end
        S_RD: begin
          res_r   <= rd_ok_r ? rd : 6'sd0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {1'b0, 1'b1, res_r};
            state_r     <= S_IDLE;
          end
        end
        S_GRD: begin
          if (k_r == 4'd0 && used_cell && !full) begin
            for (int i = 0; i < 3; i++) begin
              win_r[i][0] <= win_r[i][1];
              win_r[i][1] <= win_r[i][2];
            end
          end
          if (k_r != 4'd0) begin
            if (used_cell) win_r[ps[3:2]][ps[1:0]] <= rd;
            else ctr_r <= rd;
          end
          if (k_r == nreads) state_r <= S_GEV;
          else k_r <= k_r + 4'd1;
        end
        S_GEV: begin
          if (use_mod) state_r <= S_GMOD;
        end
        S_GMOD: ;
        default: state_r <= S_IDLE;
      endcase
      if (gen_we) begin
        k_r <= '0;
        if (last_row) begin
          r_r <= '0;
          if (last_col) begin
            bank_r  <= !bank_r;
            state_r <= S_OUT;
          end else begin
            c_r     <= c_r + CW'(1);
            state_r <= S_GRD;
          end
        end else begin
          r_r     <= r_r + RW'(1);
          state_r <= S_GRD;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PPGA_ASSERT(a_lfsr_nonzero, lfsr_r != 16'd0)
  `PPGA_ASSERT_IMPL(a_bank_flip, bank_r != $past(bank_r), $past(state_r == S_GEV || state_r == S_GMOD))
  `PPGA_ASSERT_IMPL(a_gen_write_once, gen_we, state_r == S_GEV || state_r == S_GMOD)
endmodule
`default_nettype wire

>>> design/ppga_ram.sv
// generic single write, single read memory with registered read
// no dependencies
`default_nettype none
module ppga_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/ppga_mod.sv
// bit-serial remainder unit, 16-bit value by 8-bit modulus, one bit a cycle
// depends on ppga_pkg and the assertion header
`include "predator_prey_grid_automaton_top_assert.svh"
`default_nettype none
module ppga_mod (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [7:0]  divisor,
  output ppga_pkg::mod_st_t st
);
  import ppga_pkg::*;

  logic        busy_r, done_r;
  logic [3:0]  cnt_r;
  logic [15:0] dv_r;
  logic [7:0]  rem_r, dvs_r, rem_nxt;
  logic [8:0]  trial;

  assign trial   = {rem_r, dv_r[15]};
  assign rem_nxt = (trial >= {1'b0, dvs_r}) ? 8'(trial - {1'b0, dvs_r}) : trial[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv_r  <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dv_r  <= dv_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign st.done = done_r;
  assign st.zero = (rem_r == 8'd0);

  `PPGA_ASSERT_IMPL(a_no_restart, start, !busy_r)
  `PPGA_ASSERT_IMPL(a_done_after_busy, done_r, $past(busy_r))
  `PPGA_ASSERT_IMPL(a_done_idle, done_r, !busy_r)
endmodule
`default_nettype wire

>>> dv/predator_prey_grid_automaton_top_tb.sv
// self-checking testbench for the predator-prey grid automaton top level
// drives cell write, read, step and unused-type requests with random idling, checks every reply
// depends on ppga_pkg and predator_prey_grid_automaton_top
`timescale 1ns / 100ps
`default_nettype none
module predator_prey_grid_automaton_top_tb;
  import ppga_pkg::*;

  localparam int NCOL = 64;
  localparam int NROW = 64;
  localparam int NCELL = NCOL * NROW;
  localparam int STALL_LIMIT = 400000;

  typedef struct {
    logic [1:0] req;
    int col;
    int row;
    int val;
    bit chk;
    int expv;
  } req_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  cell_t grid_q[2][NCELL];
  bit cur_bank;
  logic [15:0] death_lfsr_q;
  int width_r, height_r, fmax_r, smax_r, fbreed_r, sbreed_r, modulus_r;

  cell_t replies_due[$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int stall_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  predator_prey_grid_automaton_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function automatic int clamp_dim(int v);
    if (v < 3) return 3;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic bit shark_draw_zero();
    logic [15:0] s;
    s = {1'b0, death_lfsr_q[15:1]};
    if (death_lfsr_q[0]) s = s ^ 16'hB400;
    death_lfsr_q = s;
    if (modulus_r == 0) return 1'b0;
    return (int'(s) % modulus_r) == 0;
  endfunction

  function automatic void next_generation();
    int w, h, v, n, nv, fish, shark, fb, sb, nc, nr;
    bit rnd;
    w = clamp_dim(width_r);
    h = clamp_dim(height_r);
    grid_q[!cur_bank] = grid_q[cur_bank];
    for (int c = 0; c < w; c++) begin
      for (int r = 0; r < h; r++) begin
        fish = 0; shark = 0; fb = 0; sb = 0;
        v = grid_q[cur_bank][r * NCOL + c];
        for (int dc = -1; dc <= 1; dc++) begin
          for (int dr = -1; dr <= 1; dr++) begin
            if (dc != 0 || dr != 0) begin
              nc = (c + w + dc) % w;
              nr = (r + h + dr) % h;
              n = grid_q[cur_bank][nr * NCOL + nc];
              if (n > 0) begin
                fish++;
                if (n >= fbreed_r) fb++;
              end else if (n < 0) begin
                shark++;
                if (-n >= sbreed_r) sb++;
              end
            end
          end
        end
        if (v == 0) begin
          if (fish >= 3 && fb >= 3 && shark < 4) nv = 1;
          else if (shark >= 3 && sb >= 3 && fish < 4) nv = -1;
          else nv = 0;
        end else if (v > 0) begin
          if (v > fmax_r || shark >= 5 || fish == 8) nv = 0;
          else nv = (v < 31) ? v + 1 : 31;
        end else begin
          rnd = shark_draw_zero();
          if (-v > smax_r || (shark >= 6 && fish == 0) || rnd) nv = 0;
          else nv = (v > -31) ? v - 1 : -31;
        end
        grid_q[!cur_bank][r * NCOL + c] = cell_t'(nv);
      end
    end
    cur_bank = !cur_bank;
  endfunction

  function automatic cell_t predict_reply(logic [1:0] req, int col, int row, int val);
    cell_t v6;
    int idx;
    v6 = cell_t'(val);
    if (v6 == -6'sd32) v6 = -6'sd31;
    idx = row * NCOL + col;
    case (req)
      REQ_WRITE: grid_q[cur_bank][idx] = v6;
      REQ_READ: return grid_q[cur_bank][idx];
      REQ_STEP: next_generation();
      default: ;
    endcase
    return '0;
  endfunction

  task automatic send_request(logic [1:0] req, int col, int row, int val, bit chk, int expv);
    cell_t pred;
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, 6'(val), 6'(row), 6'(col), req};
    do @(posedge clk); while (!in_tready);
    pred = predict_reply(req, col & 63, row & 63, val);
    replies_due.push_back(chk ? cell_t'(expv) : pred);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 16'(val);
    @(negedge clk);
    case (idx)
      CFG_WIDTH: width_r = val & 8'h7F;
      CFG_HEIGHT: height_r = val & 8'h7F;
      CFG_FMAX: fmax_r = val & 5'h1F;
      CFG_SMAX: smax_r = val & 5'h1F;
      CFG_FBREED: fbreed_r = val & 5'h1F;
      CFG_SBREED: sbreed_r = val & 5'h1F;
      CFG_MODULUS: modulus_r = val & 8'hFF;
      default: death_lfsr_q = ((val & 16'hFFFF) == 0) ? 16'd1 : 16'(val);
    endcase
  endtask

  task automatic load_settings(int w, int h, int fm, int sm, int fb, int sb, int md, int sd);
    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (replies_due.size() == 0);
    repeat (20) @(negedge clk);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_FMAX, fm);
    write_reg(CFG_SMAX, sm);
    write_reg(CFG_FBREED, fb);
    write_reg(CFG_SBREED, sb);
    write_reg(CFG_MODULUS, md);
    write_reg(CFG_SEED, sd);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int random_cell();
    int k;
    k = $urandom_range(99);
    if (k < 40) return $urandom_range(1, 12);
    if (k < 70) return -$urandom_range(1, 12);
    if (k < 90) return 0;
    return int'($signed(6'($urandom_range(0, 63))));
  endfunction

  task automatic run_phase(int n);
    int w, h, k, col, row;
    w = clamp_dim(width_r);
    h = clamp_dim(height_r);
    for (int i = 0; i < n; i++) begin
      k = (i < 8) ? 0 : $urandom_range(99);
      col = $urandom_range(0, w - 1);
      row = $urandom_range(0, h - 1);
      if ($urandom_range(9) == 0) begin
        col = $urandom_range(0, 63);
        row = $urandom_range(0, 63);
      end
      if (k < 40) send_request(REQ_WRITE, col, row, random_cell(), 0, 0);
      else if (k < 68) send_request(REQ_READ, col, row, $urandom_range(0, 63), 0, 0);
      else if (k < 88) send_request(REQ_STEP, $urandom_range(0, 63),
                                    $urandom_range(0, 63), $urandom_range(0, 63), 0, 0);
      else if (k < 94) send_request(2'd3, $urandom_range(0, 63),
                                    $urandom_range(0, 63), $urandom_range(0, 63), 0, 0);
      else send_request(REQ_WRITE, col, row, -32, 0, 0);
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    cell_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply word with no request outstanding");
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (out_tdata[5:0] !== want) begin
          $error("read_value expected %0d got %0d", want, $signed(out_tdata[5:0]));
          errors++;
        end
        if (out_tdata[6] !== 1'b1) begin
          $error("request_done expected 1 got %b", out_tdata[6]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  req_row_t directed[$] = '{
    '{REQ_READ, 0, 0, 0, 1, 0},
    '{REQ_READ, 63, 63, 0, 1, 0},
    '{REQ_WRITE, 63, 63, 31, 1, 0},
    '{REQ_READ, 63, 63, 0, 1, 31},
    '{REQ_WRITE, 0, 0, -32, 1, 0},
    '{REQ_READ, 0, 0, 0, 1, -31},
    '{REQ_WRITE, 1, 0, -31, 1, 0},
    '{REQ_READ, 1, 0, 0, 1, -31},
    '{2'd3, 63, 63, -1, 1, 0},
    '{REQ_WRITE, 2, 1, 3, 1, 0},
    '{REQ_WRITE, 0, 2, 2, 1, 0},
    '{REQ_WRITE, 1, 2, 5, 1, 0},
    '{REQ_WRITE, 10, 10, -3, 1, 0},
    '{REQ_WRITE, 11, 10, -4, 1, 0},
    '{REQ_WRITE, 10, 11, -5, 1, 0},
    '{REQ_STEP, 0, 0, 0, 1, 0},
    '{REQ_READ, 1, 1, 0, 0, 0},
    '{REQ_READ, 2, 1, 0, 0, 0},
    '{REQ_READ, 11, 11, 0, 0, 0},
    '{REQ_READ, 63, 63, 0, 0, 0},
    '{REQ_READ, 0, 0, 0, 0, 0},
    '{REQ_STEP, 63, 63, 31, 1, 0},
    '{REQ_READ, 1, 1, 0, 0, 0}
  };

  initial begin
    foreach (grid_q[b, i]) grid_q[b][i] = '0;
    cur_bank = 0;
    width_r = 64; height_r = 64; fmax_r = 10; smax_r = 20;
    fbreed_r = 2; sbreed_r = 3; modulus_r = 48; death_lfsr_q = 16'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    snd_idle = 22; rcv_idle = 47;
    foreach (directed[i])
      send_request(directed[i].req, directed[i].col, directed[i].row, directed[i].val,
                   directed[i].chk, directed[i].expv);

    load_settings(3, 3, 1, 1, 1, 1, 1, 16'hFFFF);
    run_phase(22);
    load_settings(5, 4, 30, 30, 31, 31, 255, 0);
    run_phase(20);
    snd_idle = 47; rcv_idle = 22;
    load_settings(0, 2, 10, 20, 2, 3, 0, $urandom_range(1, 65535));
    run_phase(22);
    load_settings(127, 64, 5, 8, 1, 2, 7, 16'hACE1);
    run_phase(14);
    snd_idle = 0; rcv_idle = 0;
    load_settings(6, 6, 3, 12, 2, 2, 3, $urandom_range(1, 65535));
    run_phase(22);
    load_settings($urandom_range(3, 10), $urandom_range(3, 10), $urandom_range(1, 30),
                  $urandom_range(1, 30), $urandom_range(1, 4), $urandom_range(1, 4),
                  $urandom_range(1, 255), $urandom_range(1, 65535));
    run_phase(22);

    in_tvalid <= 1'b0;
    wait (replies_due.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
